// ===== src/knr_pkg.sv =====
// Package for the k-nearest-within-radius block: sizes, register codes and
// the structs passed between the distance, list and emit stages.
// No dependencies.
package knr_pkg;

  localparam int NEAREST_COUNT = 5;
  localparam int INDEX_BITS    = 16;

  localparam int COORD_W    = 16;
  localparam int IDX_W      = 16;
  localparam int SQ_W       = 32;  // (2^16-1)^2 fits in 32 bits
  localparam int DIST_W     = 33;  // sum of two squares
  localparam int CFG_DATA_W = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int RANK_OUT_W = 3;

  localparam int IDX_CMP_BITS = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int CNT_W        = $clog2(NEAREST_COUNT + 1);
  localparam int RANK_W       = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_RADIUS_SQ      = 3'd2,
    REG_EXCLUDE_ENABLE = 3'd3,
    REG_EXCLUDED_INDEX = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [DIST_W-1:0]         radius_sq;
    logic                      exclude_enable;
    logic [IDX_W-1:0]          excluded_index;
  } cfg_t;

  // candidate leaving the distance pipeline
  typedef struct packed {
    logic                      ok;    // passes all filters
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         sq_dist;
  } cand_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         sq_dist;
  } slot_t;

  typedef slot_t [NEAREST_COUNT-1:0] slot_arr_t;

endpackage

// ===== src/knr_if.sv =====
// Handshake interfaces for point beats and result beats.
// Depends on knr_pkg.
interface knr_point_if;
  import knr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      point_active;
  logic                      last_point;

  modport source (output valid, point_index, point_x, point_y, point_active, last_point,
                  input ready);
  modport sink (input valid, point_index, point_x, point_y, point_active, last_point,
                output ready);
endinterface

interface knr_result_if;
  import knr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [RANK_OUT_W-1:0]     rank;
  logic                      found;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [DIST_W-1:0]         target_dist_sq;
  logic                      last_result;

  modport source (output valid, rank, found, target_x, target_y, target_dist_sq,
                  last_result, input ready);
  modport sink (input valid, rank, found, target_x, target_y, target_dist_sq,
                last_result, output ready);
endinterface

// ===== src/knr_dist.sv =====
// Distance pipeline: input register, squares, then sum and filter.
// Depends on knr_pkg and knr_if.
module knr_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  knr_point_if.sink       point_i,
  input  knr_pkg::cfg_t   cfg_i,
  input  logic            adv_i,
  output logic            c_valid_o,
  output knr_pkg::cand_t  c_o
);
  import knr_pkg::*;

  logic                      a_valid_q, b_valid_q, c_valid_q;
  logic signed [COORD_W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic                      a_keep_q, a_last_q, b_keep_q, b_last_q;
  logic [SQ_W-1:0]           b_sqx_q, b_sqy_q;
  cand_t                     c_q;

  logic                      excl;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [2*COORD_W+1:0] px2, py2;
  logic [DIST_W-1:0]         sum;

  assign point_i.ready = adv_i;

  assign excl = cfg_i.exclude_enable &&
                (point_i.point_index[IDX_CMP_BITS-1:0] ==
                 cfg_i.excluded_index[IDX_CMP_BITS-1:0]);

  assign dx  = {a_x_q[COORD_W-1], a_x_q} - {cfg_i.center_x[COORD_W-1], cfg_i.center_x};
  assign dy  = {a_y_q[COORD_W-1], a_y_q} - {cfg_i.center_y[COORD_W-1], cfg_i.center_y};
  assign px2 = dx * dx;
  assign py2 = dy * dy;
  assign sum = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= point_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_x_q    <= point_i.point_x;
      a_y_q    <= point_i.point_y;
      a_keep_q <= point_i.point_active && !excl;
      a_last_q <= point_i.last_point;

      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_keep_q <= a_keep_q;
      b_last_q <= a_last_q;
      b_sqx_q  <= px2[SQ_W-1:0];
      b_sqy_q  <= py2[SQ_W-1:0];

      c_q.ok      <= b_keep_q && (sum != '0) && (sum <= cfg_i.radius_sq);
      c_q.last    <= b_last_q;
      c_q.x       <= b_x_q;
      c_q.y       <= b_y_q;
      c_q.sq_dist <= sum;
    end
  end

  assign c_valid_o = c_valid_q;
  assign c_o       = c_q;

endmodule

// ===== src/knr_list.sv =====
// Sorted list of the nearest slots with parallel compare-and-shift insert.
// Depends on knr_pkg.
module knr_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             c_valid_i,
  input  knr_pkg::cand_t                   c_i,
  input  logic                             adv_i,
  output knr_pkg::slot_arr_t               snap_o,
  output logic [knr_pkg::NEAREST_COUNT-1:0] snap_vld_o,
  output logic [knr_pkg::NEAREST_COUNT-1:0] vld_o
);
  import knr_pkg::*;

  slot_arr_t                slot_q, slot_n;
  logic [NEAREST_COUNT-1:0] vld_q, vld_n, vld_d, beats;
  logic                     ins, flush;

  // empty slot counts as infinitely far; strict compare keeps older on ties
  always_comb begin
    for (int i = 0; i < NEAREST_COUNT; i++) begin
      beats[i] = !vld_q[i] || (c_i.sq_dist < slot_q[i].sq_dist);
    end
  end

  assign ins   = c_valid_i && adv_i && c_i.ok && beats[NEAREST_COUNT-1];
  assign flush = c_valid_i && adv_i && c_i.last;

  always_comb begin
    slot_n = slot_q;
    vld_n  = vld_q;
    if (ins && beats[0]) begin
      slot_n[0] = '{x: c_i.x, y: c_i.y, sq_dist: c_i.sq_dist};
      vld_n[0]  = 1'b1;
    end
    for (int i = 1; i < NEAREST_COUNT; i++) begin
      if (ins && beats[i]) begin
        vld_n[i] = 1'b1;
        if (beats[i-1]) begin
          slot_n[i] = slot_q[i-1];
          vld_n[i]  = vld_q[i-1];
        end else begin
          slot_n[i] = '{x: c_i.x, y: c_i.y, sq_dist: c_i.sq_dist};
        end
      end
    end
    vld_d = flush ? '0 : vld_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_n;
  end

  assign snap_o     = slot_n;
  assign snap_vld_o = vld_n;
  assign vld_o      = vld_q;

endmodule

// ===== src/knr_emit.sv =====
// Emit buffer holding one list snapshot, drained into the result register.
// Depends on knr_pkg and knr_if.
module knr_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              snap_we_i,
  input  knr_pkg::slot_arr_t                snap_i,
  input  logic [knr_pkg::NEAREST_COUNT-1:0] snap_vld_i,
  output logic                              buf_free_o,
  knr_result_if.source                      result_o
);
  import knr_pkg::*;

  slot_arr_t            ebuf_q;
  logic [CNT_W-1:0]     e_cnt_q, snap_cnt;
  logic [RANK_W-1:0]    e_rank_q;
  logic                 e_none_q;
  logic                 o_valid_q, load;

  assign snap_cnt   = CNT_W'($countones(snap_vld_i));
  assign buf_free_o = (e_cnt_q == '0);
  assign load       = !buf_free_o && (!o_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_cnt_q   <= '0;
      e_rank_q  <= '0;
      e_none_q  <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (snap_we_i) begin
        e_cnt_q  <= (snap_cnt == '0) ? CNT_W'(1) : snap_cnt;
        e_none_q <= (snap_cnt == '0);
        e_rank_q <= '0;
      end else if (load) begin
        e_cnt_q  <= e_cnt_q - CNT_W'(1);
        e_rank_q <= e_rank_q + RANK_W'(1);
      end
      if (load) begin
        o_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_we_i) begin
      ebuf_q <= snap_i;
    end else if (load) begin
      for (int i = 0; i < NEAREST_COUNT - 1; i++) begin
        ebuf_q[i] <= ebuf_q[i+1];
      end
    end
    if (load) begin
      result_o.rank           <= RANK_OUT_W'(e_rank_q);
      result_o.found          <= !e_none_q;
      result_o.target_x       <= e_none_q ? '0 : ebuf_q[0].x;
      result_o.target_y       <= e_none_q ? '0 : ebuf_q[0].y;
      result_o.target_dist_sq <= e_none_q ? '0 : ebuf_q[0].sq_dist;
      result_o.last_result    <= (e_cnt_q == CNT_W'(1));
    end
  end

  assign result_o.valid = o_valid_q;

endmodule

// ===== src/k_nearest_within_radius.sv =====
// Top level of the k-nearest-within-radius selector: config registers,
// distance pipeline, sorted list and emit buffer. Depends on knr_pkg, knr_if,
// knr_dist, knr_list and knr_emit.
//
//   port       dir  beat                            handshake
//   point_i    in   index, x, y, active, last flag  valid/ready
//   result_o   out  rank, found, x, y, dist, last   valid/ready
//   cfg_*_i    in   register index + data           write enable only
//
// One point per cycle while point_i.ready is high. Each taken point passes
// the input register, the squares and the sum and radius check to the list.
// On a last point the updated list is copied to the emit buffer, which sends
// one result per cycle while result_o.ready is high; a last point that finds
// the buffer still busy waits at the list stage and holds point_i.ready low
// until the buffer is empty. Reset clears config, list and pipeline valid bits.
module k_nearest_within_radius (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  knr_point_if.sink                        point_i,
  knr_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [knr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [knr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import knr_pkg::*;

  cfg_t                     cfg_q;
  logic                     c_valid, adv, hold, buf_free, snap_we;
  cand_t                    cand;
  slot_arr_t                snap;
  logic [NEAREST_COUNT-1:0] snap_vld, list_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X:       cfg_q.center_x       <= cfg_data_i[COORD_W-1:0];
        REG_CENTER_Y:       cfg_q.center_y       <= cfg_data_i[COORD_W-1:0];
        REG_RADIUS_SQ:      cfg_q.radius_sq      <= cfg_data_i[DIST_W-1:0];
        REG_EXCLUDE_ENABLE: cfg_q.exclude_enable <= cfg_data_i[0];
        REG_EXCLUDED_INDEX: cfg_q.excluded_index <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // a finished list can only move on once the emit buffer is empty
  assign hold    = c_valid && cand.last && !buf_free;
  assign adv     = !hold;
  assign snap_we = c_valid && cand.last && adv;

  knr_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_i   (point_i),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .c_valid_o (c_valid),
    .c_o       (cand)
  );

  knr_list u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .c_valid_i  (c_valid),
    .c_i        (cand),
    .adv_i      (adv),
    .snap_o     (snap),
    .snap_vld_o (snap_vld),
    .vld_o      (list_vld)
  );

  knr_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_we_i  (snap_we),
    .snap_i     (snap),
    .snap_vld_i (snap_vld),
    .buf_free_o (buf_free),
    .result_o   (result_o)
  );

  // occupied slots always form a prefix of the list
  a_list_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((list_vld & (list_vld + NEAREST_COUNT'(1))) == '0))
    else $error("list valid bits not contiguous");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.found) |-> (result_o.last_result && result_o.rank == '0))
    else $error("not-found beat is not a lone rank-0 final beat");

  a_in_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.found) |->
      (result_o.target_dist_sq != '0 && result_o.target_dist_sq <= cfg_q.radius_sq))
    else $error("reported point outside radius");

  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && !result_o.last_result) |=>
      (result_o.valid && result_o.rank == $past(result_o.rank) + RANK_OUT_W'(1)))
    else $error("result ranks not consecutive");

endmodule

// ===== verif/knr_list_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for k_nearest_within_radius: shadows the register writes, keeps
// its own sorted nearest list per scan and compares every result beat.
// Depends on knr_pkg and knr_if.
module knr_list_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  knr_point_if                           point_i,
  knr_result_if                          result_i,
  input  logic                           cfg_we_i,
  input  logic [knr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [knr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             errors_o
);
  import knr_pkg::*;

  typedef struct packed {
    logic [RANK_OUT_W-1:0]     rank;
    logic                      found;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         sq_dist;
    logic                      last;
  } hit_t;

  cfg_t                     shadow;
  slot_t                    near_slot [NEAREST_COUNT];
  logic [NEAREST_COUNT-1:0] near_held;
  hit_t                     due_hits [$];
  int                       mismatches = 0;

  function automatic void check_field(input string name,
                                      input logic [DIST_W-1:0] want,
                                      input logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [DIST_W:0] dx, dy;  // one bit over DIST_W so the sum cannot wrap
    logic [DIST_W:0]        dsq;
    logic                   keep;
    hit_t                   got, want, due;
    int                     pos, n;
    if (!rst_ni) begin
      shadow = '0;
      near_held = '0;
      due_hits.delete();
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CENTER_X:       shadow.center_x = cfg_data_i[COORD_W-1:0];
          REG_CENTER_Y:       shadow.center_y = cfg_data_i[COORD_W-1:0];
          REG_RADIUS_SQ:      shadow.radius_sq = cfg_data_i[DIST_W-1:0];
          REG_EXCLUDE_ENABLE: shadow.exclude_enable = cfg_data_i[0];
          REG_EXCLUDED_INDEX: shadow.excluded_index = cfg_data_i[IDX_W-1:0];
          default: ;
        endcase
      end

      if (result_i.valid && result_i.ready) begin
        got = '{rank: result_i.rank, found: result_i.found, x: result_i.target_x,
                y: result_i.target_y, sq_dist: result_i.target_dist_sq,
                last: result_i.last_result};
        if (due_hits.size() == 0) begin
          $error("result beat with nothing outstanding: rank %0d found %0d",
                 got.rank, got.found);
          mismatches++;
        end else begin
          want = due_hits.pop_front();
          check_field("rank", DIST_W'(want.rank), DIST_W'(got.rank));
          check_field("found", DIST_W'(want.found), DIST_W'(got.found));
          check_field("target_x", DIST_W'($unsigned(want.x)), DIST_W'($unsigned(got.x)));
          check_field("target_y", DIST_W'($unsigned(want.y)), DIST_W'($unsigned(got.y)));
          check_field("target_dist_sq", want.sq_dist, got.sq_dist);
          check_field("last_result", DIST_W'(want.last), DIST_W'(got.last));
        end
      end

      if (point_i.valid && point_i.ready) begin
        dx = (DIST_W+1)'($signed(point_i.point_x)) - (DIST_W+1)'($signed(shadow.center_x));
        dy = (DIST_W+1)'($signed(point_i.point_y)) - (DIST_W+1)'($signed(shadow.center_y));
        dsq = dx * dx + dy * dy;
        // exclusion is checked regardless of the active flag
        keep = point_i.point_active && dsq != 0 && dsq <= {1'b0, shadow.radius_sq} &&
               !(shadow.exclude_enable &&
                 point_i.point_index[IDX_CMP_BITS-1:0] ==
                 shadow.excluded_index[IDX_CMP_BITS-1:0]);
        // strict less-than: an equal distance stays behind the earlier point
        if (keep && (!near_held[NEAREST_COUNT-1] ||
                     dsq < near_slot[NEAREST_COUNT-1].sq_dist)) begin
          pos = NEAREST_COUNT - 1;
          while (pos > 0 && (!near_held[pos-1] || dsq < near_slot[pos-1].sq_dist)) begin
            near_slot[pos] = near_slot[pos-1];
            near_held[pos] = near_held[pos-1];
            pos--;
          end
          near_slot[pos] = '{x: point_i.point_x, y: point_i.point_y,
                             sq_dist: dsq[DIST_W-1:0]};
          near_held[pos] = 1'b1;
        end

        if (point_i.last_point) begin
          n = 0;
          for (int i = 0; i < NEAREST_COUNT && near_held[i]; i++) begin
            due = '{rank: RANK_OUT_W'(i), found: 1'b1, x: near_slot[i].x,
                    y: near_slot[i].y, sq_dist: near_slot[i].sq_dist, last: 1'b0};
            due_hits.insert(due_hits.size(), due);
            n++;
          end
          if (n == 0) begin
            due = '{rank: '0, found: 1'b0, x: '0, y: '0, sq_dist: '0, last: 1'b1};
            due_hits.insert(due_hits.size(), due);
          end else begin
            due_hits[due_hits.size()-1].last = 1'b1;
          end
          near_held = '0;
        end
      end

      pending_o <= due_hits.size();
      errors_o <= mismatches;
    end
  end

endmodule

// ===== verif/k_nearest_within_radius_tb.sv =====
`timescale 1ns / 100ps
// Top of the k_nearest_within_radius testbench: drives registers and point
// scans, stalls the result side and reports the verdict of knr_list_checker.
// Depends on knr_pkg, knr_if, knr_list_checker and k_nearest_within_radius.
module k_nearest_within_radius_tb;
  import knr_pkg::*;

  localparam int POINT_TARGET  = 430;
  localparam int CALM_TAIL     = 60;   // final points go out with no idling
  localparam int SETTLE_CYCLES = 12;   // 3-stage pipe plus margin
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED = CFG_IDX_W'(REG_EXCLUDED_INDEX + 1);
  localparam logic [CFG_DATA_W-1:0] RADIUS_MAX   = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                  pending;
  int                  errors;
  int                  points_sent = 0;
  int                  hold_left = 0;
  bit                  idling = 1'b1;
  logic signed [15:0]  ctr_x = '0, ctr_y = '0, prev_x = '0, prev_y = '0;
  logic [15:0]         skip_idx = '0;
  int                  spread = 8;

  knr_point_if  point_bus ();
  knr_result_if result_bus ();

  k_nearest_within_radius uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  knr_list_checker list_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_bus),
    .result_i    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side back-pressure, random bursts with ready held low
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 9);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("k_nearest_within_radius: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic signed [15:0] cx, input logic signed [15:0] cy,
                           input logic [CFG_DATA_W-1:0] rad, input logic excl,
                           input logic [15:0] idx);
    write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
    write_reg(REG_RADIUS_SQ, rad);
    write_reg(REG_EXCLUDE_ENABLE, CFG_DATA_W'(excl));
    write_reg(REG_EXCLUDED_INDEX, CFG_DATA_W'(idx));
    cfg_we_i <= 1'b0;
    ctr_x = cx;
    ctr_y = cy;
    skip_idx = idx;
  endtask

  task automatic send_point(input logic [15:0] idx, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic active,
                            input logic last);
    if (idling && $urandom_range(0, 4) == 0) begin
      point_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    point_bus.valid <= 1'b1;
    point_bus.point_index <= idx;
    point_bus.point_x <= x;
    point_bus.point_y <= y;
    point_bus.point_active <= active;
    point_bus.last_point <= last;
    do @(posedge clk_i); while (!point_bus.ready);
    points_sent++;
  endtask

  // sender holds off until every outstanding result beat has drained
  task automatic drain();
    point_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_setup();
    logic signed [15:0]    cx, cy;
    logic [CFG_DATA_W-1:0] rad;
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      cy = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
    end else begin
      cx = $urandom;
      cy = $urandom;
    end
    spread = 1 << (3 * $urandom_range(1, 5));
    case ($urandom_range(0, 7))
      0:       rad = '0;
      1:       rad = RADIUS_MAX;
      2:       rad = {$urandom, $urandom};
      default: rad = CFG_DATA_W'(longint'(spread) * spread * $urandom_range(1, 8) / 4);
    endcase
    configure(cx, cy, rad, $urandom_range(0, 1), $urandom);
  endtask

  task automatic random_scan();
    int                 len, pick;
    logic [15:0]        idx;
    logic signed [15:0] x, y;
    logic               active;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
    for (int n = 0; n < len; n++) begin
      if (POINT_TARGET - points_sent <= CALM_TAIL)
        idling = 1'b0;
      pick = $urandom_range(0, 15);
      idx = $urandom;
      x = ctr_x + 16'(int'($urandom_range(0, 2 * spread)) - spread);
      y = ctr_y + 16'(int'($urandom_range(0, 2 * spread)) - spread);
      case (pick)
        0: begin x = ctr_x; y = ctr_y; end        // zero distance
        1: begin x = $urandom; y = $urandom; end
        2: idx = skip_idx;
        3: begin x = prev_x; y = prev_y; end      // tie with the previous point
        default: ;
      endcase
      active = $urandom_range(0, 7) != 0;
      send_point(idx, x, y, active, n == len - 1);
      prev_x = x;
      prev_y = y;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    point_bus.valid = 1'b0;
    point_bus.point_index = '0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_active = 1'b0;
    point_bus.last_point = 1'b0;
    result_bus.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset: zero radius, scan comes back empty
    send_point(16'd0, 16'sd5, 16'sd5, 1'b1, 1'b1);
    drain();

    // corner centre, full radius, exclusion of the top index
    configure(16'sh8000, 16'sh7fff, RADIUS_MAX, 1'b1, 16'hffff);
    send_point(16'd0, 16'sh8000, 16'sh7fff, 1'b1, 1'b0);  // on the centre
    send_point(16'd1, 16'sh7fff, 16'sh8000, 1'b1, 1'b0);  // largest distance
    send_point(16'hffff, 16'sd0, 16'sd0, 1'b1, 1'b0);     // excluded
    send_point(16'hffff, 16'sd0, 16'sd0, 1'b0, 1'b0);     // excluded and inactive
    send_point(16'd2, 16'sd0, 16'sd0, 1'b0, 1'b0);        // inactive
    send_point(16'd3, 16'sh8001, 16'sh7fff, 1'b1, 1'b0);  // dist 1
    send_point(16'd4, 16'sh8000, 16'sh7ffe, 1'b1, 1'b0);  // dist 1, tie
    send_point(16'd5, 16'sh8008, 16'sh7ff8, 1'b1, 1'b0);  // dist 113
    send_point(16'd6, 16'sh8044, 16'sh7fbc, 1'b1, 1'b0);  // list now full
    send_point(16'd7, 16'sh8008, 16'sh7ff8, 1'b1, 1'b0);  // 113 again, evicts the far one
    send_point(16'd8, 16'sh8001, 16'sh7fff, 1'b1, 1'b0);
    send_point(16'd9, 16'sh8007, 16'sh7ff7, 1'b1, 1'b1);  // equals last slot, dropped
    drain();

    // exclusion off, small radius: exactly on the radius is kept
    configure(16'sd100, -16'sd100, 33'd25, 1'b0, 16'hffff);
    send_point(16'hffff, 16'sd103, -16'sd96, 1'b1, 1'b0);
    send_point(16'd10, 16'sd100, -16'sd94, 1'b1, 1'b0);
    send_point(16'd11, 16'sd101, -16'sd100, 1'b1, 1'b1);
    drain();

    // a write past the register map must change nothing
    write_reg(REG_EXCLUDE_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_EXCLUDED_INDEX, '0);
    write_reg(REG_UNMAPPED, RADIUS_MAX);
    cfg_we_i <= 1'b0;
    send_point(16'd0, 16'sd100, -16'sd99, 1'b1, 1'b1);  // only point excluded
    drain();

    while (points_sent < POINT_TARGET) begin
      idling = (POINT_TARGET - points_sent > CALM_TAIL) && $urandom_range(0, 3) != 0;
      random_setup();
      repeat ($urandom_range(2, 6)) random_scan();
      drain();
    end

    if (errors == 0)
      $display("k_nearest_within_radius: match");
    else
      $display("k_nearest_within_radius: mismatch");
    $finish;
  end

endmodule
